FILE: hdl/balc_pkg.sv
// Package for the binary alpha layer compositor: default sizes, pixel
// constants, request codes and the controller state type. No dependencies.
`timescale 1ns / 1ps

package balc_pkg;

  localparam int unsigned GRID_W_DEF = 128;
  localparam int unsigned GRID_H_DEF = 128;
  localparam int unsigned LAYERS_DEF = 4;
  localparam int unsigned SCALE_DEF  = 8;

  // Input and output beat widths, fixed by the field list.
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned GRID_IDX_W = 7;
  localparam int unsigned SCREEN_W   = 10;
  localparam int unsigned PIXEL_W    = 32;

  localparam logic [7:0]  OPAQUE_CODE = 8'hff;
  localparam int unsigned ALPHA_SHIFT = 24;

  typedef enum logic {
    REQ_WRITE   = 1'b0,
    REQ_COMPOSE = 1'b1
  } req_kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EMIT  = 4'b1000
  } ctl_state_t;

  function automatic logic pixel_opaque(input logic [PIXEL_W-1:0] px);
    pixel_opaque = (px[ALPHA_SHIFT +: 8] == OPAQUE_CODE);
  endfunction

endpackage

FILE: hdl/binary_alpha_layer_compositor_top.sv
// Top level of the binary alpha layer compositor: layer store memory,
// compose sequencer and block emitter. Depends on balc_pkg.
`timescale 1ns / 1ps
// Reset runs a clearing pass that writes zero to every store word, one per cycle, over
// 2**(clog2(LAYERS)+clog2(GRID_H)+clog2(GRID_W)) words (65536 by default), no beats taken.
// Write beats can follow back to back.
// A compose reads the layers one per cycle through the single read port, then emits
// SCALE*SCALE beats one per cycle while out_tready is high; no new beat is taken until
// the block's last beat is sent. An out-of-grid compose is dropped and the block stays idle.

module binary_alpha_layer_compositor_top #(
  parameter int unsigned GRID_W = balc_pkg::GRID_W_DEF,
  parameter int unsigned GRID_H = balc_pkg::GRID_H_DEF,
  parameter int unsigned LAYERS = balc_pkg::LAYERS_DEF,
  parameter int unsigned SCALE  = balc_pkg::SCALE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: layer[1:0], grid_x[8:2], grid_y[15:9], pixel_value[47:16].
  input  logic [balc_pkg::IN_DATA_W-1:0]      in_tdata,
  // Fields from bit 0: req_type[0], use_sprite[1].
  input  logic [balc_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: color[31:0], screen_x[41:32], screen_y[51:42], zero pad[55:52].
  output logic [balc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  // The store is addressed by concatenating layer, row and column indexes,
  // so every field gets a power-of-two span.
  localparam int unsigned XW    = $clog2(GRID_W);
  localparam int unsigned YW    = $clog2(GRID_H);
  localparam int unsigned LW    = $clog2(LAYERS);
  localparam int unsigned AW    = LW + YW + XW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned LCW   = $clog2(LAYERS + 1);
  localparam int unsigned SW    = (SCALE > 1) ? $clog2(SCALE) : 1;

  typedef logic [AW-1:0] addr_t;

  // Input field extraction.
  logic [1:0]                       in_layer;
  logic [balc_pkg::GRID_IDX_W-1:0]  in_gx;
  logic [balc_pkg::GRID_IDX_W-1:0]  in_gy;
  logic [balc_pkg::PIXEL_W-1:0]     in_px;
  logic                             in_req;
  logic                             in_spr;
  logic                             in_fire;
  logic                             in_on_grid;
  logic [10:0]                      in_gx_ext;
  logic [10:0]                      in_gy_ext;
  logic [3:0]                       in_layer_ext;

  assign in_layer     = in_tdata[1:0];
  assign in_gx        = in_tdata[8:2];
  assign in_gy        = in_tdata[15:9];
  assign in_px        = in_tdata[47:16];
  assign in_req       = in_tuser[0];
  assign in_spr       = in_tuser[1];
  assign in_fire      = in_tvalid & in_tready;
  assign in_gx_ext    = {4'b0, in_gx};
  assign in_gy_ext    = {4'b0, in_gy};
  assign in_layer_ext = {2'b0, in_layer};
  assign in_on_grid   = (in_gx_ext < 11'(GRID_W)) && (in_gy_ext < 11'(GRID_H));

  // Control and payload registers.
  balc_pkg::ctl_state_t state_r, state_nxt;
  addr_t                clr_r, clr_nxt;
  logic [LCW-1:0]       cnt_r, cnt_nxt;
  logic [SW-1:0]        dx_r, dx_nxt;
  logic [SW-1:0]        dy_r, dy_nxt;

  logic [balc_pkg::GRID_IDX_W-1:0] gx_r, gy_r;
  logic [1:0]                      spr_lay_r;
  logic                            use_spr_r;
  logic [balc_pkg::PIXEL_W-1:0]    spr_px_r;
  logic [balc_pkg::PIXEL_W-1:0]    color_r, color_nxt;

  // Layer store: one write port, one registered read port.
  logic [balc_pkg::PIXEL_W-1:0] mem [DEPTH];
  logic [balc_pkg::PIXEL_W-1:0] mem_q;
  logic                         mem_we;
  addr_t                        mem_wa;
  logic [balc_pkg::PIXEL_W-1:0] mem_wd;
  logic                         mem_re;
  addr_t                        mem_ra;

  logic [10:0]                  gx_r_ext, gy_r_ext;
  logic [LCW-1:0]               fold_lay;
  logic [balc_pkg::PIXEL_W-1:0] cand;
  logic                         blk_last;

  assign gx_r_ext = {4'b0, gx_r};
  assign gy_r_ext = {4'b0, gy_r};
  assign fold_lay = cnt_r - LCW'(1);
  assign blk_last = (dx_r == SW'(SCALE - 1)) && (dy_r == SW'(SCALE - 1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // Write port: the clearing sweep after reset, else accepted write beats
  // that land on a present layer inside the grid.
  always_comb begin
    if (state_r == balc_pkg::ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = '0;
    end else begin
      mem_we = in_fire && (in_req == balc_pkg::REQ_WRITE) && in_on_grid &&
               (in_layer_ext < 4'(LAYERS));
      mem_wa = {in_layer_ext[LW-1:0], in_gy_ext[YW-1:0], in_gx_ext[XW-1:0]};
      mem_wd = in_px;
    end
  end

  // Read port walks the layers of the latched cell, layer 0 first.
  assign mem_re = (state_r == balc_pkg::ST_READ) && (cnt_r < LCW'(LAYERS));
  assign mem_ra = {cnt_r[LW-1:0], gy_r_ext[YW-1:0], gx_r_ext[XW-1:0]};

  // The word read last cycle belongs to layer cnt_r-1. Layer 0 seeds the
  // background as is; later layers replace it only when fully opaque, with the
  // request's own pixel standing in on the sprite layer unless that is layer 0.
  always_comb begin
    if (use_spr_r && (fold_lay != '0) && (4'(fold_lay) == 4'(spr_lay_r))) begin
      cand = spr_px_r;
    end else begin
      cand = mem_q;
    end
    color_nxt = color_r;
    if (state_r == balc_pkg::ST_READ && cnt_r != '0) begin
      if (fold_lay == '0 || balc_pkg::pixel_opaque(cand)) begin
        color_nxt = cand;
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    unique case (state_r)
      balc_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + addr_t'(1);
        if (clr_r == addr_t'(DEPTH - 1)) begin
          state_nxt = balc_pkg::ST_IDLE;
        end
      end
      balc_pkg::ST_IDLE: begin
        if (in_fire && (in_req == balc_pkg::REQ_COMPOSE) && in_on_grid) begin
          state_nxt = balc_pkg::ST_READ;
          cnt_nxt   = '0;
        end
      end
      balc_pkg::ST_READ: begin
        cnt_nxt = cnt_r + LCW'(1);
        if (cnt_r == LCW'(LAYERS)) begin
          state_nxt = balc_pkg::ST_EMIT;
          dx_nxt    = '0;
          dy_nxt    = '0;
        end
      end
      balc_pkg::ST_EMIT: begin
        if (out_tready) begin
          if (blk_last) begin
            state_nxt = balc_pkg::ST_IDLE;
          end else if (dx_r == SW'(SCALE - 1)) begin
            dx_nxt = '0;
            dy_nxt = dy_r + SW'(1);
          end else begin
            dx_nxt = dx_r + SW'(1);
          end
        end
      end
      default: begin
        state_nxt = balc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= balc_pkg::ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
    end
  end

  // Request payload is latched on every accepted beat; only composes use it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      gx_r      <= in_gx;
      gy_r      <= in_gy;
      spr_lay_r <= in_layer;
      use_spr_r <= in_spr;
      spr_px_r  <= in_px;
    end
    color_r <= color_nxt;
  end

  // Output beat. Screen coordinates wrap at 1024 like the 10-bit fields.
  logic [balc_pkg::SCREEN_W-1:0] scr_x, scr_y;

  assign scr_x = 10'(gx_r) * 10'(SCALE) + 10'(dx_r);
  assign scr_y = 10'(gy_r) * 10'(SCALE) + 10'(dy_r);

  assign in_tready  = (state_r == balc_pkg::ST_IDLE);
  assign out_tvalid = (state_r == balc_pkg::ST_EMIT);
  assign out_tlast  = blk_last;
  assign out_tdata  = {4'b0, scr_y, scr_x, color_r};

`ifndef NO_ASSERTIONS
  // Input and output never handshake in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a block is being emitted");

  // The read walk never runs past the last layer.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == balc_pkg::ST_READ) |-> (cnt_r <= LCW'(LAYERS)))
    else $error("layer counter out of range");

  // The clearing sweep only ends after the top address is written.
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == balc_pkg::ST_CLEAR && state_r != balc_pkg::ST_CLEAR)
      |-> ($past(clr_r) == addr_t'(DEPTH - 1)))
    else $error("clearing sweep ended early");

  // The final beat of a block returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (state_r == balc_pkg::ST_IDLE))
    else $error("sequencer not idle after last beat");
`endif

endmodule
